FILE: hdl/bdf_pkg.sv
// ============================================================================
// bdf_pkg - shared types and constants for the button debounce state machine
// Holds the state encoding, the next-state table, the configuration register
// indexes and reset values, and the result beat layout.
// ============================================================================
`default_nettype none

package bdf_pkg;

    // Timer width default and config register width
    localparam int TIMER_WIDTH_DEF = 16;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_INDEX_W     = 2;

    // Register reset values
    localparam logic                  ACTIVE_LEVEL_RST  = 1'b0;
    localparam logic [CFG_DATA_W-1:0] PRESS_TICKS_RST   = 16'd250;
    localparam logic [CFG_DATA_W-1:0] RELEASE_TICKS_RST = 16'd100;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ACTIVE_LEVEL  = 2'd0,
        CFG_PRESS_TICKS   = 2'd1,
        CFG_RELEASE_TICKS = 2'd2
    } cfg_idx_t;

    // Button states
    typedef enum logic [2:0] {
        ST_IDLE         = 3'd0,
        ST_EDGE1        = 3'd1,
        ST_TRIGGERED    = 3'd2,
        ST_PRESSED      = 3'd3,
        ST_PRESS_HOLD   = 3'd4,
        ST_EDGE2        = 3'd5,
        ST_RELEASE_HOLD = 3'd6,
        ST_RELEASED     = 3'd7
    } state_t;

    // One result beat
    typedef struct packed {
        logic   pressed_pulse;
        state_t button_state;
    } result_t;

    // Next-state table, row = current state, column = {timed_out, active}
    localparam logic [2:0] NEXT_TABLE [0:7][0:3] = '{
        '{3'd0, 3'd1, 3'd0, 3'd1},
        '{3'd5, 3'd2, 3'd5, 3'd1},
        '{3'd5, 3'd2, 3'd5, 3'd3},
        '{3'd5, 3'd4, 3'd5, 3'd4},
        '{3'd5, 3'd4, 3'd5, 3'd4},
        '{3'd6, 3'd1, 3'd0, 3'd1},
        '{3'd6, 3'd1, 3'd7, 3'd1},
        '{3'd0, 3'd1, 3'd0, 3'd1}
    };

    function automatic state_t next_state(input state_t cur, input logic [1:0] sel);
        next_state = state_t'(NEXT_TABLE[cur][sel]);
    endfunction

endpackage

`default_nettype wire

FILE: hdl/bdf_core.sv
// ============================================================================
// bdf_core - state, timeout counter and configuration registers
// Takes one pin sample per accepted beat, steps the timeout counter, looks up
// the next state and produces the result beat in the same cycle.
// ============================================================================
`default_nettype none

module bdf_core #(
    parameter int TIMER_WIDTH = bdf_pkg::TIMER_WIDTH_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cfg_we,
    input  wire  [bdf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire  [bdf_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire                               accept,
    input  wire                               pin_level,
    input  wire                               tick,
    output bdf_pkg::result_t                  result
);

    logic                            active_level_reg;
    logic [bdf_pkg::CFG_DATA_W-1:0]  press_ticks_reg;
    logic [bdf_pkg::CFG_DATA_W-1:0]  release_ticks_reg;

    bdf_pkg::state_t                 state_reg;
    bdf_pkg::state_t                 state_next;
    logic [TIMER_WIDTH-1:0]          count_reg;
    logic [TIMER_WIDTH-1:0]          count_next;
    logic [TIMER_WIDTH-1:0]          count_dec;
    logic [1:0]                      sel;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_level_reg  <= bdf_pkg::ACTIVE_LEVEL_RST;
            press_ticks_reg   <= bdf_pkg::PRESS_TICKS_RST;
            release_ticks_reg <= bdf_pkg::RELEASE_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bdf_pkg::CFG_ACTIVE_LEVEL:  active_level_reg  <= cfg_data[0];
                bdf_pkg::CFG_PRESS_TICKS:   press_ticks_reg   <= cfg_data;
                bdf_pkg::CFG_RELEASE_TICKS: release_ticks_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // Count down on a tick, stick at zero
    always_comb
    begin
        if (tick && (count_reg != '0))
            count_dec = count_reg - TIMER_WIDTH'(1);
        else
            count_dec = count_reg;
        sel = {(count_dec == '0), (pin_level == active_level_reg)};
    end

    // Next state
    always_comb
    begin
        state_next = bdf_pkg::next_state(state_reg, sel);
    end

    // Counter reload and result outputs
    always_comb
    begin
        unique case (state_next)
            bdf_pkg::ST_EDGE1: count_next = TIMER_WIDTH'(press_ticks_reg);
            bdf_pkg::ST_EDGE2: count_next = TIMER_WIDTH'(release_ticks_reg);
            default:           count_next = count_dec;
        endcase
        result.button_state  = state_next;
        result.pressed_pulse = (state_next == bdf_pkg::ST_PRESSED);
    end

    // Advance state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bdf_pkg::ST_IDLE;
            count_reg <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/bdf_outbuf.sv
// ============================================================================
// bdf_outbuf - result register with skid stage
// Holds result beats for the master side so the slave side keeps flowing
// while the consumer stalls, until the skid register is full as well.
// ============================================================================
`default_nettype none

module bdf_outbuf (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    input  bdf_pkg::result_t    push_data,
    output logic                ready,
    output logic                out_valid,
    input  wire                 out_ready,
    output bdf_pkg::result_t    out_data
);

    logic               out_valid_reg;
    logic               out_valid_next;
    logic               skid_valid_reg;
    logic               skid_valid_next;
    bdf_pkg::result_t   out_reg;
    bdf_pkg::result_t   out_next;
    bdf_pkg::result_t   skid_reg;
    bdf_pkg::result_t   skid_next;
    logic               pop;

    assign pop       = out_valid_reg && out_ready;
    assign ready     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Route beats between result and skid registers
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (pop || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = push_data;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
    end

    // Hold valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

FILE: hdl/button_debounce_fsm.sv
// ============================================================================
// button_debounce_fsm - eight-state button qualifier
// Debounces a sampled button pin against a tick-driven timeout and reports
// the new state with a one-beat pressed pulse for every input beat.
// ============================================================================
//
//   channel   direction  handshake                 payload
//   s_*       in         s_tvalid / s_tready       s_tdata[1:0] = tick, pin_level
//   m_*       out        m_tvalid / m_tready       m_tdata[3:0] = pulse, button_state
//   cfg_*     in         cfg_we (no wait)          cfg_index, cfg_data[15:0]
//
// One beat per cycle while m_tready keeps up; each result is registered in the
// result register after the table lookup, or in the skid register on a stall.
// A two-deep output stage (result plus skid register) keeps s_tready high
// while m_tready stalls with one beat held; s_tready drops only when both hold.
// Reset puts the machine in idle with the timeout counter at zero and loads
// the register defaults: active level 0, press time 250, release time 100.
// ============================================================================
`default_nettype none

module button_debounce_fsm #(
    parameter int TIMER_WIDTH = bdf_pkg::TIMER_WIDTH_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    // slave side
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [7:0]                       s_tdata,   // [0] pin_level, [1] tick
    // master side
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [7:0]                       m_tdata,   // [2:0] button_state, [3] pressed_pulse
    // configuration
    input  wire                              cfg_we,
    input  wire  [bdf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire  [bdf_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic               accept;
    bdf_pkg::result_t   result;
    bdf_pkg::result_t   out_data;

    assign accept = s_tvalid && s_tready;

    // State machine and timeout counter
    bdf_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .pin_level (s_tdata[0]),
        .tick      (s_tdata[1]),
        .result    (result)
    );

    // Result register and skid stage
    bdf_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result),
        .ready     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    // Pack the result beat, zero fill to a byte
    assign m_tdata = {4'b0000, out_data};

endmodule

`default_nettype wire

FILE: hdl/bdf_checker.sv
// ============================================================================
// bdf_checker - port-level checks for the button debounce state machine
// Watches the stream ports over time and flags beats that break the result
// encoding or the output buffering.
// ============================================================================
`default_nettype none

module bdf_checker (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        s_tvalid,
    input  wire        s_tready,
    input  wire        m_tvalid,
    input  wire        m_tready,
    input  wire [7:0]  m_tdata
);

    // Pulse marks exactly the pressed state
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3] == (m_tdata[2:0] == bdf_pkg::ST_PRESSED)))
        else $error("pressed pulse does not match state");

    // Fill bits stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:4] == 4'b0000))
        else $error("nonzero fill bits on result beat");

    // Back-pressure only while a result is waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("slave side stalled with empty output");

    // Stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result beat changed");

    // Pressed is left on the very next accepted beat when output flows freely
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && (m_tdata[2:0] == bdf_pkg::ST_PRESSED) && $past(m_tready)
            && $past(s_tvalid && s_tready) && s_tvalid && s_tready)
        |=> (m_tvalid && (m_tdata[2:0] != bdf_pkg::ST_PRESSED)))
        else $error("pressed state repeated");

endmodule

bind button_debounce_fsm bdf_checker u_bdf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: tb/button_debounce_fsm_tb.sv
// ============================================================================
// button_debounce_fsm_tb - self-checking bench for the button debounce FSM
// Streams pin/tick samples into the block, predicts each new state and the
// pressed pulse from a behavioral copy of the machine and its timeout
// counter, and compares every result beat field by field. Both stream sides
// see random gaps and stalls. Register settings change only while idle.
// ============================================================================
`default_nettype none

module button_debounce_fsm_tb;

    // Expected result beat
    typedef struct {
        bdf_pkg::state_t button_state;
        logic            pressed_pulse;
    } exp_beat_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = 8'h00;   // [0] pin_level, [1] tick
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;            // [2:0] button_state, [3] pressed_pulse
    logic              cfg_we    = 1'b0;
    bdf_pkg::cfg_idx_t cfg_index = bdf_pkg::CFG_ACTIVE_LEVEL;
    logic [15:0]       cfg_data  = 16'h0000;

    // Predicted machine: configuration copy and state
    logic              lvl_active  = bdf_pkg::ACTIVE_LEVEL_RST;
    logic [15:0]       press_len   = bdf_pkg::PRESS_TICKS_RST;
    logic [15:0]       release_len = bdf_pkg::RELEASE_TICKS_RST;
    bdf_pkg::state_t   dbc_state   = bdf_pkg::ST_IDLE;
    logic [15:0]       dbc_count   = 16'h0000;

    exp_beat_t   pending_results[$];

    // Run bookkeeping
    int          errors           = 0;
    int          items_sent       = 0;
    int          beats_checked    = 0;
    int          pulses_seen      = 0;
    int          settings_applied = 0;
    logic [7:0]  states_seen      = 8'h00;
    logic        src_gaps         = 1'b1;
    logic        sink_stalls      = 1'b1;
    int          stall_left       = 0;

    button_debounce_fsm uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock: period 4
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Idle length: mostly none, some short, a few long
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 24);
    endfunction

    // Next state of the debounce machine for one sample
    function automatic bdf_pkg::state_t next_dbc_state(input bdf_pkg::state_t cur,
                                                       input logic timed_out,
                                                       input logic is_active);
        bdf_pkg::state_t nxt;
        case (cur)
            bdf_pkg::ST_IDLE, bdf_pkg::ST_RELEASED:
                nxt = is_active ? bdf_pkg::ST_EDGE1 : bdf_pkg::ST_IDLE;
            bdf_pkg::ST_EDGE1:
                nxt = !is_active ? bdf_pkg::ST_EDGE2 :
                      (timed_out ? bdf_pkg::ST_EDGE1 : bdf_pkg::ST_TRIGGERED);
            bdf_pkg::ST_TRIGGERED:
                nxt = !is_active ? bdf_pkg::ST_EDGE2 :
                      (timed_out ? bdf_pkg::ST_PRESSED : bdf_pkg::ST_TRIGGERED);
            bdf_pkg::ST_PRESSED, bdf_pkg::ST_PRESS_HOLD:
                nxt = is_active ? bdf_pkg::ST_PRESS_HOLD : bdf_pkg::ST_EDGE2;
            bdf_pkg::ST_EDGE2:
                nxt = is_active ? bdf_pkg::ST_EDGE1 :
                      (timed_out ? bdf_pkg::ST_IDLE : bdf_pkg::ST_RELEASE_HOLD);
            default:
                // release hold
                nxt = is_active ? bdf_pkg::ST_EDGE1 :
                      (timed_out ? bdf_pkg::ST_RELEASED : bdf_pkg::ST_RELEASE_HOLD);
        endcase
        return nxt;
    endfunction

    // Advance the predicted machine by one accepted sample and queue its result
    task automatic predict_sample(input logic pin, input logic tk);
        exp_beat_t       beat;
        bdf_pkg::state_t nxt;
        // count down first, never below zero
        if (tk && dbc_count != 16'h0000)
            dbc_count = dbc_count - 16'd1;
        nxt = next_dbc_state(dbc_state, dbc_count == 16'h0000, pin == lvl_active);
        dbc_state = nxt;
        // reload on entry to either edge state
        if (nxt == bdf_pkg::ST_EDGE1)
            dbc_count = press_len;
        else if (nxt == bdf_pkg::ST_EDGE2)
            dbc_count = release_len;
        beat.button_state  = nxt;
        beat.pressed_pulse = (nxt == bdf_pkg::ST_PRESSED);
        pending_results.push_back(beat);
    endtask

    task automatic report_mismatch(input string what);
        if (errors < 40)
            $display("MISMATCH @%0t: %s", $realtime, what);
        errors++;
    endtask

    // Send one sample beat, with an optional gap ahead of it
    task automatic send_sample(input logic pin, input logic tk);
        int gap;
        gap = src_gaps ? pick_idle() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, tk, pin};
        do
            @(posedge clk);
        while (!s_tready);
        predict_sample(pin, tk);
        items_sent++;
    endtask

    // Hold a level for a number of samples, with some bounce and ticks mostly on
    task automatic send_level(input logic level, input int count);
        logic pin;
        for (int i = 0; i < count; i++)
        begin
            pin = level;
            if ($urandom_range(0, 99) < 8)
                pin = ~level;
            send_sample(pin, $urandom_range(0, 99) < 80);
        end
    endtask

    // Drain the block, then write all three registers back to back
    task automatic apply_settings(input logic lvl, input logic [15:0] press,
                                  input logic [15:0] rel);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= bdf_pkg::CFG_ACTIVE_LEVEL;
        cfg_data  <= {15'b0, lvl};
        @(posedge clk);
        cfg_index <= bdf_pkg::CFG_PRESS_TICKS;
        cfg_data  <= press;
        @(posedge clk);
        cfg_index <= bdf_pkg::CFG_RELEASE_TICKS;
        cfg_data  <= rel;
        @(posedge clk);
        cfg_we <= 1'b0;
        lvl_active  = lvl;
        press_len   = press;
        release_len = rel;
        settings_applied++;
    endtask

    // Sink side: random stalls of m_tready
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (sink_stalls && $urandom_range(0, 99) < 20)
        begin
            stall_left <= pick_idle();
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Compare each result beat with the oldest expectation
    always @(posedge clk)
    begin : check_results
        exp_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result beat %h with nothing expected", m_tdata));
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[2:0] !== want.button_state)
                    report_mismatch($sformatf("button_state %0d, expected %0d (%s)",
                                    m_tdata[2:0], want.button_state,
                                    want.button_state.name()));
                if (m_tdata[3] !== want.pressed_pulse)
                    report_mismatch($sformatf("pressed_pulse %b, expected %b",
                                    m_tdata[3], want.pressed_pulse));
                if (m_tdata[7:4] !== 4'b0000)
                    report_mismatch($sformatf("pad bits %b, expected zero", m_tdata[7:4]));
                states_seen[want.button_state] = 1'b1;
                if (want.pressed_pulse)
                    pulses_seen++;
                beats_checked++;
            end
        end
    end

    // Reset values: active low, long press and release times
    task automatic test_reset_defaults();
        send_sample(1'b1, 1'b1);
        send_sample(1'b0, 1'b0);
        send_sample(1'b0, 1'b1);
        send_sample(1'b1, 1'b0);
        send_sample(1'b1, 1'b1);
        send_sample(1'b0, 1'b0);
    endtask

    // Walk every state with short times, including a tick on a zero counter
    task automatic test_full_press_cycle();
        apply_settings(1'b1, 16'd2, 16'd1);
        send_sample(1'b0, 1'b1);
        send_sample(1'b0, 1'b1);
        send_sample(1'b1, 1'b0);
        send_sample(1'b1, 1'b1);
        send_sample(1'b1, 1'b0);
        send_sample(1'b1, 1'b1);
        send_sample(1'b1, 1'b1);
        send_sample(1'b0, 1'b0);
        send_sample(1'b0, 1'b0);
        send_sample(1'b0, 1'b1);
        send_sample(1'b0, 1'b1);
    endtask

    // Zero reloads time out at once; full-scale reloads barely move
    task automatic test_reload_extremes();
        apply_settings(1'b0, 16'h0000, 16'hFFFF);
        send_sample(1'b0, 1'b0);
        send_sample(1'b0, 1'b1);
        send_sample(1'b1, 1'b0);
        send_sample(1'b1, 1'b1);
        apply_settings(1'b1, 16'hFFFF, 16'h0000);
        send_sample(1'b1, 1'b0);
        send_sample(1'b1, 1'b1);
        send_sample(1'b0, 1'b1);
        send_sample(1'b0, 1'b0);
    endtask

    // Press/release bursts with bounce and noise over several settings
    task automatic test_random_presses();
        logic        lvl_tab   [0:8] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        logic [15:0] press_tab [0:8] = '{16'd3, 16'd1, 16'd0, 16'd0, 16'd7, 16'd2,
                                         16'hFFFF, 16'd12, 16'd40};
        logic [15:0] rel_tab   [0:8] = '{16'd2, 16'd1, 16'd0, 16'd5, 16'd4, 16'hFFFF,
                                         16'd3, 16'd9, 16'd30};
        int          count_tab [0:8] = '{150, 150, 120, 120, 150, 60, 60, 180, 200};
        int          start;
        int          hold_max;
        int          rel_max;
        for (int ph = 0; ph < 9; ph++)
        begin
            apply_settings(lvl_tab[ph], press_tab[ph], rel_tab[ph]);
            // some phases run with no idling on one side
            src_gaps    = (ph % 3 != 1);
            sink_stalls = (ph % 4 != 2);
            hold_max = (2 * press_tab[ph] + 6 > 90) ? 90 : 2 * press_tab[ph] + 6;
            rel_max  = (2 * rel_tab[ph] + 6 > 90) ? 90 : 2 * rel_tab[ph] + 6;
            start    = items_sent;
            while (items_sent - start < count_tab[ph])
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // noise burst
                    repeat ($urandom_range(1, 8))
                        send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
                else
                begin
                    send_level(lvl_tab[ph], $urandom_range(1, hold_max));
                    send_level(~lvl_tab[ph], $urandom_range(1, rel_max));
                end
            end
        end
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
    endtask

    // Main sequence
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_full_press_cycle();
        test_reload_extremes();
        test_random_presses();

        // Drain outstanding results, then watch for stray beats
        s_tvalid <= 1'b0;
        for (int i = 0; i < 500 && pending_results.size() != 0; i++)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                            pending_results.size()));

        $display("Summary: %0d samples sent, %0d result beats checked, %0d pressed pulses",
                 items_sent, beats_checked, pulses_seen);
        $display("Summary: %0d register settings applied, states reached (bit per state) %b",
                 settings_applied, states_seen);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
hdl/bdf_pkg.sv
hdl/bdf_core.sv
hdl/bdf_outbuf.sv
hdl/button_debounce_fsm.sv
hdl/bdf_checker.sv
tb/button_debounce_fsm_tb.sv
